[rtl/mote_pkg.sv]
`timescale 1ns / 1ps

package mote_pkg;

   localparam int TIME_W     = 32;
   localparam int CMD_W      = 8;
   localparam int CHAN_W     = 3;
   localparam int MODE_W     = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   typedef logic [TIME_W-1:0]     time_type;
   typedef logic [CMD_W-1:0]      cmd_type;
   typedef logic [CHAN_W-1:0]     chan_type;
   typedef logic [MODE_W-1:0]     mode_type;
   typedef logic [CSR_IDX_W-1:0]  csr_idx_type;
   typedef logic [CSR_DATA_W-1:0] csr_data_type;

   // mode codes
   localparam mode_type MODE_OFF      = 2'd0;
   localparam mode_type MODE_PEND_ON  = 2'd1;
   localparam mode_type MODE_ON       = 2'd2;
   localparam mode_type MODE_PEND_OFF = 2'd3;

   // register indexes
   localparam csr_idx_type CSR_OFF_MIN_PERIOD = 2'd0;
   localparam csr_idx_type CSR_ON_MIN_PERIOD  = 2'd1;
   localparam csr_idx_type CSR_CHANNEL_INDEX  = 2'd2;

   typedef struct packed {
      time_type off_min_period;
      time_type on_min_period;
      chan_type channel_index;
   } cfg_type;

   typedef struct packed {
      logic     output_on;
      mode_type mode_code;
   } result_type;

endpackage

[rtl/mote_if.sv]
`timescale 1ns / 1ps

interface mote_req_if;
   logic               valid;
   logic               ready;
   mote_pkg::time_type time_now;
   mote_pkg::cmd_type  command_vector;

   modport source (output valid, output time_now, output command_vector, input ready);
   modport sink   (input valid, input time_now, input command_vector, output ready);
endinterface

interface mote_rsp_if;
   logic               valid;
   logic               ready;
   logic               output_on;
   mote_pkg::mode_type mode_code;

   modport source (output valid, output output_on, output mode_code, input ready);
   modport sink   (input valid, input output_on, input mode_code, output ready);
endinterface

interface mote_csr_if;
   logic                   valid;
   logic                   ready;
   mote_pkg::csr_idx_type  index;
   mote_pkg::csr_data_type data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/mote_csr.sv]
`timescale 1ns / 1ps

module mote_csr (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   wr_en,
   input  mote_pkg::csr_idx_type  wr_index,
   input  mote_pkg::csr_data_type wr_data,
   output mote_pkg::cfg_type      cfg
);
   import mote_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (wr_index)
            CSR_OFF_MIN_PERIOD: cfg_in.off_min_period = wr_data[TIME_W-1:0];
            CSR_ON_MIN_PERIOD:  cfg_in.on_min_period  = wr_data[TIME_W-1:0];
            CSR_CHANNEL_INDEX:  cfg_in.channel_index  = wr_data[CHAN_W-1:0];
            default:            cfg_in = cfg_ff; // unmapped index, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[rtl/mote_fsm.sv]
`timescale 1ns / 1ps

module mote_fsm (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  mote_pkg::cfg_type    cfg,
   input  mote_pkg::time_type   time_now,
   input  mote_pkg::cmd_type    command_vector,
   output mote_pkg::result_type result,
   output mote_pkg::mode_type   mode
);
   import mote_pkg::*;

   mode_type mode_ff;
   mode_type mode_in;
   time_type last_ff;
   time_type last_in;

   logic     cmd;
   time_type elapsed;
   logic     off_done;
   logic     on_done;
   time_type off_clamp;
   time_type on_clamp;

   assign cmd       = command_vector[cfg.channel_index];
   assign elapsed   = time_now - last_ff;
   assign off_done  = (elapsed >= cfg.off_min_period);
   assign on_done   = (elapsed >= cfg.on_min_period);
   assign off_clamp = time_now - cfg.off_min_period;
   assign on_clamp  = time_now - cfg.on_min_period;

   always_comb begin
      mode_in = mode_ff;
      last_in = last_ff;
      unique case (mode_ff)
         MODE_OFF: begin
            if (!off_done) begin
               if (cmd) mode_in = MODE_PEND_ON;
            end else if (cmd) begin
               mode_in = MODE_ON;
               last_in = time_now;
            end else begin
               last_in = off_clamp;
            end
         end
         MODE_PEND_ON: begin
            if (off_done) begin
               if (cmd) begin
                  mode_in = MODE_ON;
                  last_in = time_now;
               end else begin
                  last_in = off_clamp;
               end
            end
            if (!cmd) mode_in = MODE_OFF;
         end
         MODE_ON: begin
            if (!on_done) begin
               if (!cmd) mode_in = MODE_PEND_OFF;
            end else if (!cmd) begin
               mode_in = MODE_OFF;
               last_in = time_now;
            end else begin
               last_in = on_clamp;
            end
         end
         MODE_PEND_OFF: begin
            if (on_done) begin
               if (!cmd) begin
                  mode_in = MODE_OFF;
                  last_in = time_now;
               end else begin
                  last_in = on_clamp;
               end
            end
            if (cmd) mode_in = MODE_ON;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_OFF;
         last_ff <= '0;
      end else if (step) begin
         mode_ff <= mode_in;
         last_ff <= last_in;
      end
   end

   assign result.output_on = (mode_in == MODE_ON) || (mode_in == MODE_PEND_OFF);
   assign result.mode_code = mode_in;
   assign mode             = mode_ff;

endmodule

[rtl/min_on_off_time_enforcer.sv]
`timescale 1ns / 1ps

// minimum on/off time enforcer for one channel of an 8-bit command vector. each request
// transaction is one tick carrying a free-running 32-bit timestamp and the command vector;
// the bit picked by channel_index is the command. a four-state machine (off, pending-on,
// on, pending-off) holds the output off for at least off_min_period and on for at least
// on_min_period time units, keeping an early command pending until its period has run.
// every request gives exactly one response with the qualified level and the mode code.
// a transaction passes through an input register and then the result register before its
// response is offered; a response that is not taken holds the result register and the input
// stage. one transaction can be taken every cycle while the response channel does not stall;
// the rate is set by the mode logic, whose subtract/compare/update steps once per transaction.
// registers are written through the csr channel, which is always ready, and should only be
// written while no transaction is in flight.

module min_on_off_time_enforcer (
   input logic         clock,
   input logic         reset,
   mote_req_if.sink    req_chan,
   mote_rsp_if.source  rsp_chan,
   mote_csr_if.sink    csr_chan
);
   import mote_pkg::*;

   // input register stage
   logic       in_valid_ff;
   logic       in_valid_in;
   time_type   in_time_ff;
   cmd_type    in_cmd_ff;

   // result register stage
   logic       out_valid_ff;
   logic       out_valid_in;
   result_type out_result_ff;

   cfg_type    cfg;
   result_type fsm_result;
   mode_type   fsm_mode;

   logic       req_take;
   logic       advance;

   // the input stage moves on when the result register is empty or being drained
   assign advance  = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_take = req_chan.valid && req_chan.ready;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_chan.ready);

   // config registers, always ready
   assign csr_chan.ready = 1'b1;

   mote_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_chan.valid),
      .wr_index (csr_chan.index),
      .wr_data  (csr_chan.data),
      .cfg      (cfg)
   );

   // mode state and timestamp update, stepped once per transaction leaving the input stage
   mote_fsm u_fsm (
      .clock          (clock),
      .reset          (reset),
      .step           (advance),
      .cfg            (cfg),
      .time_now       (in_time_ff),
      .command_vector (in_cmd_ff),
      .result         (fsm_result),
      .mode           (fsm_mode)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_time_ff <= req_chan.time_now;
         in_cmd_ff  <= req_chan.command_vector;
      end
      if (advance) begin
         out_result_ff <= fsm_result;
      end
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.output_on = out_result_ff.output_on;
   assign rsp_chan.mode_code = out_result_ff.mode_code;

`ifndef NO_ASSERTIONS
   // the level shown must agree with the mode shown
   a_level_matches_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.output_on == rsp_chan.mode_code[1]))
      else $error("output level disagrees with mode code");

   // state only moves when a transaction leaves the input stage
   a_mode_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(fsm_mode))
      else $error("mode changed without a transaction");

   // the response loaded is the mode the state machine moved to
   a_rsp_tracks_mode: assert property (@(posedge clock) disable iff (reset)
      advance |=> (rsp_chan.valid && (rsp_chan.mode_code == fsm_mode)))
      else $error("response mode differs from state");

   // a pending stall must not drop an item held in the input stage
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |-> !req_chan.ready)
      else $error("input stage overwritten while stalled");
`endif

endmodule
